### design/vureg_pkg.sv
// ----------------------------------------------------------------------------
// vureg_pkg
// Shared constants, codes and types of the video unit CPU register port.
// ----------------------------------------------------------------------------
package vureg_pkg;

    localparam int VIDEO_ADDR_BITS  = 14;
    localparam int SPRITE_ADDR_BITS = 8;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_BITS   = 2;

    // Addresses above this read video memory directly, at or below it through the buffer
    localparam logic [15:0] DIRECT_READ_LIMIT = 16'h3EFF;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [2:0] REG_CONTROL     = 3'd0;
    localparam logic [2:0] REG_MASK        = 3'd1;
    localparam logic [2:0] REG_STATUS      = 3'd2;
    localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
    localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL      = 3'd5;
    localparam logic [2:0] REG_VIDEO_ADDR  = 3'd6;
    localparam logic [2:0] REG_VIDEO_DATA  = 3'd7;

    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_VWRITE,
        MOP_VREAD,
        MOP_SWRITE
    } t_mem_op;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [7:0]  control_value;
        logic [7:0]  mask_value;
        logic [15:0] scroll_value;
        logic [15:0] video_address;
        logic [7:0]  sprite_address;
    } t_rsp;

    typedef struct packed {
        t_mem_op                     op;
        logic [VIDEO_ADDR_BITS-1:0]  vidx;
        logic [SPRITE_ADDR_BITS-1:0] sidx;
        logic [7:0]                  data;
        logic                        direct;
        t_rsp                        regs;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clear_done;
    } t_back_status;

endpackage

### design/vureg_if.sv
// ----------------------------------------------------------------------------
// vureg request and response channels
// Valid/ready channels carrying bus requests in and results out.
// ----------------------------------------------------------------------------
interface vureg_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [2:0] reg_select;
    logic [7:0] write_byte;

    modport source (output valid, req_type, reg_select, write_byte, input ready);
    modport sink   (input valid, req_type, reg_select, write_byte, output ready);
endinterface

interface vureg_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic [7:0]  control_value;
    logic [7:0]  mask_value;
    logic [15:0] scroll_value;
    logic [15:0] video_address;
    logic [7:0]  sprite_address;

    modport source (output valid, read_byte, control_value, mask_value, scroll_value,
                    video_address, sprite_address, input ready);
    modport sink   (input valid, read_byte, control_value, mask_value, scroll_value,
                    video_address, sprite_address, output ready);
endinterface

### design/vureg_front.sv
// ----------------------------------------------------------------------------
// vureg_front
// Accepts bus requests, updates the port registers and queues memory work.
// ----------------------------------------------------------------------------
module vureg_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    vureg_req_if.sink               i_req,
    input  vureg_pkg::t_q_status    i_qstat,
    input  vureg_pkg::t_back_status i_bstat,
    output logic                    o_push,
    output vureg_pkg::t_cmd         o_cmd
);
    import vureg_pkg::*;

    logic [7:0]  r_control, n_control;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_sprite_addr, n_sprite_addr;
    logic [15:0] r_scroll, n_scroll;
    logic        r_scroll_second, n_scroll_second;
    logic [15:0] r_video_addr, n_video_addr;
    logic        r_addr_second, n_addr_second;
    logic        w_accept;

    assign i_req.ready = !i_qstat.full && i_bstat.clear_done;
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_push      = w_accept;

    always_comb begin
        n_control       = r_control;
        n_mask          = r_mask;
        n_sprite_addr   = r_sprite_addr;
        n_scroll        = r_scroll;
        n_scroll_second = r_scroll_second;
        n_video_addr    = r_video_addr;
        n_addr_second   = r_addr_second;
        o_cmd.op        = MOP_NONE;
        o_cmd.vidx      = r_video_addr[VIDEO_ADDR_BITS-1:0];
        o_cmd.sidx      = r_sprite_addr[SPRITE_ADDR_BITS-1:0];
        o_cmd.data      = i_req.write_byte;
        o_cmd.direct    = r_video_addr > DIRECT_READ_LIMIT;

        if (i_req.req_type == REQ_READ) begin
            if (i_req.reg_select == REG_VIDEO_DATA) begin
                o_cmd.op     = MOP_VREAD;
                n_video_addr = r_video_addr + 16'd1;
            end
        end else begin
            case (i_req.reg_select)
                REG_CONTROL:     n_control = i_req.write_byte;
                REG_MASK:        n_mask    = i_req.write_byte;
                REG_STATUS: begin
                end
                REG_SPRITE_ADDR: n_sprite_addr = i_req.write_byte;
                REG_SPRITE_DATA: begin
                    o_cmd.op      = MOP_SWRITE;
                    n_sprite_addr = r_sprite_addr + 8'd1;
                end
                REG_SCROLL: begin
                    if (!r_scroll_second) begin
                        n_scroll = {i_req.write_byte, 8'h00};
                    end else begin
                        n_scroll = {r_scroll[15:8], r_scroll[7:0] | i_req.write_byte};
                    end
                    n_scroll_second = !r_scroll_second;
                end
                REG_VIDEO_ADDR: begin
                    // second write ORs into whatever low byte is there now
                    if (!r_addr_second) begin
                        n_video_addr = {i_req.write_byte, 8'h00};
                    end else begin
                        n_video_addr = {r_video_addr[15:8],
                                        r_video_addr[7:0] | i_req.write_byte};
                    end
                    n_addr_second = !r_addr_second;
                end
                REG_VIDEO_DATA: begin
                    o_cmd.op     = MOP_VWRITE;
                    n_video_addr = r_video_addr + 16'd1;
                end
                default: begin
                end
            endcase
        end

        o_cmd.regs.read_byte      = 8'h00;
        o_cmd.regs.control_value  = n_control;
        o_cmd.regs.mask_value     = n_mask;
        o_cmd.regs.scroll_value   = n_scroll;
        o_cmd.regs.video_address  = n_video_addr;
        o_cmd.regs.sprite_address = n_sprite_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control       <= '0;
            r_mask          <= '0;
            r_sprite_addr   <= '0;
            r_scroll        <= '0;
            r_scroll_second <= 1'b0;
            r_video_addr    <= '0;
            r_addr_second   <= 1'b0;
        end else if (w_accept) begin
            r_control       <= n_control;
            r_mask          <= n_mask;
            r_sprite_addr   <= n_sprite_addr;
            r_scroll        <= n_scroll;
            r_scroll_second <= n_scroll_second;
            r_video_addr    <= n_video_addr;
            r_addr_second   <= n_addr_second;
        end
    end

endmodule

### design/vureg_queue.sv
// ----------------------------------------------------------------------------
// vureg_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module vureg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vureg_pkg::t_cmd      i_cmd,
    input  logic                 i_pop,
    output vureg_pkg::t_cmd      o_head,
    output vureg_pkg::t_q_status o_stat
);
    import vureg_pkg::*;

    t_cmd                      r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count;

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = r_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/vureg_back.sv
// ----------------------------------------------------------------------------
// vureg_back
// Runs queued memory work, applies the read buffer and holds the result.
// ----------------------------------------------------------------------------
module vureg_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  vureg_pkg::t_cmd         i_head,
    input  vureg_pkg::t_q_status    i_qstat,
    output logic                    o_pop,
    output vureg_pkg::t_back_status o_bstat,
    vureg_rsp_if.source             o_rsp
);
    import vureg_pkg::*;

    logic [7:0] r_video_mem  [2**VIDEO_ADDR_BITS];
    logic [7:0] r_sprite_mem [2**SPRITE_ADDR_BITS];

    logic [VIDEO_ADDR_BITS:0] r_clr_cnt;
    logic                     w_clearing;
    logic [7:0]               r_rd_data;
    logic [7:0]               r_read_buffer;
    logic                     r_s1_valid;
    t_cmd                     r_s1_cmd;
    logic                     r_out_valid;
    t_rsp                     r_out;
    t_rsp                     w_out_next;
    logic                     w_s1_move;

    assign w_clearing         = !r_clr_cnt[VIDEO_ADDR_BITS];
    assign o_bstat.clear_done = !w_clearing;

    assign w_s1_move = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop     = !i_qstat.empty && !w_clearing && (!r_s1_valid || w_s1_move);

    // memory port; the sweep after reset zeroes both memories
    always_ff @(posedge i_clk) begin
        if (w_clearing) begin
            r_video_mem[r_clr_cnt[VIDEO_ADDR_BITS-1:0]]   <= 8'h00;
            r_sprite_mem[r_clr_cnt[SPRITE_ADDR_BITS-1:0]] <= 8'h00;
        end else if (o_pop) begin
            if (i_head.op == MOP_VWRITE) begin
                r_video_mem[i_head.vidx] <= i_head.data;
            end
            if (i_head.op == MOP_SWRITE) begin
                r_sprite_mem[i_head.sidx] <= i_head.data;
            end
            if (i_head.op == MOP_VREAD) begin
                r_rd_data <= r_video_mem[i_head.vidx];
            end
        end
    end

    always_comb begin
        w_out_next = r_s1_cmd.regs;
        if (r_s1_cmd.op == MOP_VREAD) begin
            w_out_next.read_byte = r_s1_cmd.direct ? r_rd_data : r_read_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd <= i_head;
        end
        if (w_s1_move) begin
            r_out <= w_out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt     <= '0;
            r_read_buffer <= 8'h00;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (w_s1_move && r_s1_cmd.op == MOP_VREAD) begin
                r_read_buffer <= r_rd_data;
            end
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.read_byte      = r_out.read_byte;
    assign o_rsp.control_value  = r_out.control_value;
    assign o_rsp.mask_value     = r_out.mask_value;
    assign o_rsp.scroll_value   = r_out.scroll_value;
    assign o_rsp.video_address  = r_out.video_address;
    assign o_rsp.sprite_address = r_out.sprite_address;

endmodule

### design/video_unit_cpu_register_port.sv
// ----------------------------------------------------------------------------
// video_unit_cpu_register_port
// CPU register port of a picture processor: one bus request in, one result out.
// ----------------------------------------------------------------------------
// Takes one bus request per cycle while the command queue has room and the memory
// sweep is done, and returns one result per request, in order; a request enters
// the command queue, is popped with a registered video memory read, then lands in
// the output register. The rate is set by the single memory port of the back part,
// which serves one request a cycle unless the result output holds it back.
// After reset the block sweeps both memories to zero, one entry per cycle, and
// holds ready low until the sweep is done.
// ----------------------------------------------------------------------------
module video_unit_cpu_register_port (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vureg_req_if.sink   i_req,
    vureg_rsp_if.source o_rsp
);
    import vureg_pkg::*;

    t_cmd         w_push_cmd;
    t_cmd         w_head;
    t_q_status    w_qstat;
    t_back_status w_bstat;
    logic         w_push;
    logic         w_pop;

    vureg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_qstat (w_qstat),
        .i_bstat (w_bstat),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    vureg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    vureg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_bstat (w_bstat),
        .o_rsp   (o_rsp)
    );

    a_no_req_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_bstat.clear_done |-> !i_req.ready)
        else $error("request taken during memory sweep");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_push)
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

endmodule

### sim/vureg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vureg_checker
// Watches the request and result channels of the register port, keeps its
// own copy of the port state and video memory, and compares every result
// field by field against the prediction for the oldest accepted request.
// ----------------------------------------------------------------------------
module vureg_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    vureg_req_if i_req,
    vureg_rsp_if i_rsp,
    output int   o_error_count,
    output int   o_pending
);
    import vureg_pkg::*;

    localparam int VRAM_DEPTH = 1 << VIDEO_ADDR_BITS;
    localparam int MAX_PRINTS = 100;

    logic [7:0]  vram_model [VRAM_DEPTH];
    logic [7:0]  control_q;
    logic [7:0]  mask_q;
    logic [7:0]  sprite_addr_q;
    logic [7:0]  read_buffer_q;
    logic [15:0] scroll_q;
    logic [15:0] vaddr_q;
    logic        scroll_low_next;
    logic        vaddr_low_next;
    t_rsp        expected_results[$];
    t_rsp        want;
    int          result_index = 0;

    task automatic report_mismatch(string msg);
        if (o_error_count < MAX_PRINTS) begin
            $display("checker: result %0d: %s", result_index, msg);
        end
        o_error_count++;
    endtask

    task automatic check_field(string field, logic [15:0] got, logic [15:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s got %h, want %h", field, got, exp_val));
        end
    endtask

    // Applies one bus request to the model state and returns the result it causes
    function automatic t_rsp apply_bus_access(logic kind, logic [2:0] sel, logic [7:0] data);
        t_rsp       r;
        logic [7:0] here;
        r = '0;
        if (kind == REQ_READ) begin
            if (sel == REG_VIDEO_DATA) begin
                here        = vram_model[vaddr_q[VIDEO_ADDR_BITS-1:0]];
                // buffer decision uses the full address, indexing mirrors
                r.read_byte = (vaddr_q <= DIRECT_READ_LIMIT) ? read_buffer_q : here;
                read_buffer_q = here;
                vaddr_q       = vaddr_q + 16'd1;
            end
        end else begin
            case (sel)
                REG_CONTROL:     control_q     = data;
                REG_MASK:        mask_q        = data;
                REG_SPRITE_ADDR: sprite_addr_q = data;
                // sprite memory contents never reach a result, only the address
                REG_SPRITE_DATA: sprite_addr_q = sprite_addr_q + 8'd1;
                REG_SCROLL: begin
                    if (!scroll_low_next) begin
                        scroll_q = {data, 8'h00};
                    end else begin
                        scroll_q = scroll_q | {8'h00, data};
                    end
                    scroll_low_next = !scroll_low_next;
                end
                REG_VIDEO_ADDR: begin
                    if (!vaddr_low_next) begin
                        vaddr_q = {data, 8'h00};
                    end else begin
                        vaddr_q = vaddr_q | {8'h00, data};
                    end
                    vaddr_low_next = !vaddr_low_next;
                end
                REG_VIDEO_DATA: begin
                    vram_model[vaddr_q[VIDEO_ADDR_BITS-1:0]] = data;
                    vaddr_q = vaddr_q + 16'd1;
                end
                default: ;
            endcase
        end
        r.control_value  = control_q;
        r.mask_value     = mask_q;
        r.scroll_value   = scroll_q;
        r.video_address  = vaddr_q;
        r.sprite_address = sprite_addr_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            control_q       = '0;
            mask_q          = '0;
            sprite_addr_q   = '0;
            read_buffer_q   = '0;
            scroll_q        = '0;
            vaddr_q         = '0;
            scroll_low_next = 1'b0;
            vaddr_low_next  = 1'b0;
            for (int k = 0; k < VRAM_DEPTH; k++) begin
                vram_model[k] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(
                    apply_bus_access(i_req.req_type, i_req.reg_select, i_req.write_byte));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_byte", 16'(i_rsp.read_byte), 16'(want.read_byte));
                    check_field("control_value", 16'(i_rsp.control_value),
                                16'(want.control_value));
                    check_field("mask_value", 16'(i_rsp.mask_value), 16'(want.mask_value));
                    check_field("scroll_value", i_rsp.scroll_value, want.scroll_value);
                    check_field("video_address", i_rsp.video_address, want.video_address);
                    check_field("sprite_address", 16'(i_rsp.sprite_address),
                                16'(want.sprite_address));
                end
                result_index++;
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives bus requests into the register port: a directed opening over the
// register map and address corner cases, then random request sequences under
// several sender/receiver idling mixes and one long result back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import vureg_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        PH_DIRECTED,
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    logic   i_clk   = 1'b0;
    logic   i_rst_n;
    t_phase phase         = PH_DIRECTED;
    int     send_idle_pct = 0;
    int     rcv_stall_pct = 0;
    int     hold_count    = 0;
    int     sent_count    = 0;
    int     cycle_count   = 0;
    int     error_count;
    int     pending;

    vureg_req_if req_ch ();
    vureg_rsp_if rsp_ch ();

    video_unit_cpu_register_port i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    vureg_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off in the pressure phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (phase == PH_PRESSURE && hold_count < LONG_HOLD) begin
            rsp_ch.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_req(logic kind, logic [2:0] sel, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.reg_select <= sel;
        req_ch.write_byte <= data;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    task automatic set_phase(t_phase p, int idle_pct, int stall_pct);
        phase         <= p;
        rcv_stall_pct <= stall_pct;
        send_idle_pct = idle_pct;
    endtask

    // One short request sequence; most are well formed, some are noise
    task automatic emit_sequence();
        int         n;
        logic [7:0] hi;
        logic [7:0] lo;
        n  = $urandom_range(1, 6);
        lo = 8'($urandom);
        case ($urandom_range(4))
            0:       hi = 8'h3F;
            1:       hi = 8'h3E;
            2:       hi = 8'($urandom_range(8'h1F));
            3:       hi = 8'hFF;
            default: hi = 8'($urandom);
        endcase
        case ($urandom_range(10))
            0, 1: begin
                send_req(REQ_WRITE, REG_VIDEO_ADDR, hi);
                send_req(REQ_WRITE, REG_VIDEO_ADDR, lo);
            end
            2, 3: repeat (n) send_req(REQ_WRITE, REG_VIDEO_DATA, 8'($urandom));
            4, 5: repeat (n) send_req(REQ_READ, REG_VIDEO_DATA, 8'($urandom));
            6: begin
                send_req(REQ_WRITE, REG_SCROLL, hi);
                send_req(REQ_WRITE, REG_SCROLL, lo);
            end
            7: begin
                send_req(REQ_WRITE, REG_SPRITE_ADDR, 8'($urandom));
                repeat (n) send_req(REQ_WRITE, REG_SPRITE_DATA, 8'($urandom));
            end
            8: begin
                case ($urandom_range(2))
                    0:       send_req(REQ_WRITE, REG_CONTROL, 8'($urandom));
                    1:       send_req(REQ_WRITE, REG_MASK, 8'($urandom));
                    default: send_req(REQ_READ, 3'($urandom_range(REG_VIDEO_ADDR)),
                                      8'($urandom));
                endcase
            end
            9: repeat (n) send_req(1'($urandom_range(1)), 3'($urandom_range(7)),
                                   8'($urandom));
            default: begin
                // write a run, point back at it and read it back, through the buffer at or below the limit
                send_req(REQ_WRITE, REG_VIDEO_ADDR, hi);
                send_req(REQ_WRITE, REG_VIDEO_ADDR, lo);
                repeat (n) send_req(REQ_WRITE, REG_VIDEO_DATA, 8'($urandom));
                send_req(REQ_WRITE, REG_VIDEO_ADDR, hi);
                send_req(REQ_WRITE, REG_VIDEO_ADDR, lo);
                repeat (n + 1) send_req(REQ_READ, REG_VIDEO_DATA, 8'($urandom));
            end
        endcase
    endtask

    task automatic run_random(int count);
        int stop_at;
        stop_at = sent_count + count;
        while (sent_count < stop_at) begin
            emit_sequence();
        end
    endtask

    initial begin
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_WRITE;
        req_ch.reg_select <= REG_CONTROL;
        req_ch.write_byte <= 8'h00;
        i_rst_n           <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(REQ_WRITE, REG_CONTROL, 8'hFF);
        send_req(REQ_WRITE, REG_MASK, 8'h5A);
        send_req(REQ_WRITE, REG_STATUS, 8'h33);      // ignored
        send_req(REQ_WRITE, REG_SPRITE_ADDR, 8'hFF);
        send_req(REQ_WRITE, REG_SPRITE_DATA, 8'h12); // sprite address wraps
        send_req(REQ_WRITE, REG_SCROLL, 8'hAB);
        send_req(REQ_WRITE, REG_SCROLL, 8'hCD);
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'hFF);
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'hFF);
        send_req(REQ_WRITE, REG_VIDEO_DATA, 8'h77);  // video address wraps to zero
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'h3E);
        send_req(REQ_WRITE, REG_VIDEO_DATA, 8'h99);  // advance between the two halves
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'h10);
        send_req(REQ_READ, REG_VIDEO_ADDR, 8'hFF);   // no effect, toggle kept
        send_req(REQ_READ, REG_VIDEO_DATA, 8'h00);
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'h3F);
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'h00);
        send_req(REQ_WRITE, REG_VIDEO_DATA, 8'h5C);
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'h3E);
        send_req(REQ_WRITE, REG_VIDEO_ADDR, 8'hFF);
        send_req(REQ_READ, REG_VIDEO_DATA, 8'h00);   // last buffered address
        send_req(REQ_READ, REG_VIDEO_DATA, 8'h00);   // first direct address
        send_req(REQ_READ, REG_CONTROL, 8'hFF);
        send_req(REQ_WRITE, REG_CONTROL, 8'h00);
        send_req(REQ_READ, REG_STATUS, 8'h00);

        set_phase(PH_STEADY, 0, 0);
        run_random(100);
        set_phase(PH_SEND_GAPS, 79, 0);
        run_random(100);
        set_phase(PH_RECV_STALLS, 0, 79);
        run_random(100);
        set_phase(PH_BOTH, 21, 21);
        run_random(100);
        set_phase(PH_PRESSURE, 0, 0);
        run_random(30);
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/vureg_pkg.sv
design/vureg_if.sv
design/vureg_front.sv
design/vureg_queue.sv
design/vureg_back.sv
design/video_unit_cpu_register_port.sv
sim/vureg_checker.sv
sim/tb.sv
